// ===== rtl/sorted_free_list_allocator_top_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef SORTED_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define SORTED_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SFA_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfa check failed");

// Next-cycle implication, checked out of reset.
`define SFA_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfa check failed");

`endif

// ===== rtl/sfa_pkg.sv =====
// Package with types, constants and states of the free-list allocator.
package sfa_pkg;
	localparam int ARENA_UNITS  = 4096;
	localparam int HEADER_UNITS = 16;
	localparam int AW = $clog2(ARENA_UNITS);
	localparam int SW = AW + 1;
	localparam int EW = 13;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_BIG   = 3'd1;
	localparam logic [2:0] ST_NO_FIT    = 3'd2;
	localparam logic [2:0] ST_NULL_FREE = 3'd3;
	localparam logic [2:0] ST_NOT_OCC   = 3'd4;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic          occupied;
		logic          has_next;
		logic [AW-1:0] next;
		logic [SW-1:0] size;
	} hdr_t;

	localparam int HW = $bits(hdr_t);

	typedef struct packed {
		logic          we;
		logic [AW-1:0] addr;
		hdr_t          data;
	} wr_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} stat_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_START, S_FCHK, S_WALK,
		S_A_SPLIT, S_A_CAND, S_A_PREV, S_F_WHD, S_F_WPREV, S_DONE
	} state_t;
endpackage

// ===== rtl/sfa_req_if.sv =====
// Request channel interface of the allocator.
interface sfa_req_if;
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [sfa_pkg::EW-1:0] element_size;
	logic [sfa_pkg::EW-1:0] element_count;
	logic [11:0]           release_offset;

	modport source (output valid, req_type, element_size, element_count, release_offset,
		input ready);
	modport sink (input valid, req_type, element_size, element_count, release_offset,
		output ready);
endinterface

// ===== rtl/sfa_rsp_if.sv =====
// Response channel interface of the allocator.
interface sfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [11:0] payload_offset;

	modport source (output valid, status, payload_offset, input ready);
	modport sink (input valid, status, payload_offset, output ready);
endinterface

// ===== rtl/sorted_free_list_allocator_top.sv =====
// Top level of the address-ordered free-list allocator.
//
//  Channel  Dir  Handshake     Beat contents
//  req      in   valid/ready   req_type, element_size, element_count, release_offset
//  rsp      out  valid/ready   status, payload_offset
//  cfg      in   cfg_we        fit_policy in cfg_wdata
//
// Free-list headers are read one per cycle while a request walks the list. An allocate
// with no fitting block ends after the walk; oversize allocates, allocates on an empty
// list and frees below the header size end without a walk, frees of a block that is not
// occupied after the header check. The next request can be accepted in the same cycle
// that the beat appears. After reset a clearing pass writes all 4096 headers, one per
// cycle, with no request accepted. A waiting beat does not block the input; the request
// taken meanwhile holds in its last cycle until the output register frees.
`include "sorted_free_list_allocator_top_defines.svh"
module sorted_free_list_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	sfa_req_if.sink    req,
	sfa_rsp_if.source  rsp
);
	sfa_pkg::wr_t           wr;
	logic [sfa_pkg::AW-1:0] raddr;
	logic [sfa_pkg::HW-1:0] rdata_raw;
	sfa_pkg::hdr_t          rdata;
	sfa_pkg::stat_t         stat;
	logic                   rsp_failed;
	logic                   rsp_has_off;

	assign rdata = sfa_pkg::hdr_t'(rdata_raw);

	// Header memory.
	sfa_hdr_ram #(
		.DEPTH (sfa_pkg::ARENA_UNITS),
		.WIDTH (sfa_pkg::HW)
	) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (rdata_raw)
	);

	// List walker and updater.
	sfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.wr        (wr),
		.raddr     (raddr),
		.rdata     (rdata),
		.stat      (stat)
	);

	// Output beat properties used by the checks.
	assign rsp_failed  = rsp.valid && (rsp.status != sfa_pkg::ST_OK);
	assign rsp_has_off = rsp.valid && (rsp.payload_offset != '0);

	// Checks on the sequencer.
	`SFA_ASSERT_IMP(a_no_req_clear, stat.clearing, !req.ready)
	`SFA_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready)
	`SFA_ASSERT_IMP(a_fail_no_off, rsp_failed, rsp.payload_offset == '0)
	`SFA_ASSERT_IMP(a_off_past_hdr, rsp_has_off, rsp.payload_offset >= 12'(sfa_pkg::HEADER_UNITS))
endmodule

// ===== rtl/sfa_hdr_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module sfa_hdr_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 27
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/sfa_ctrl.sv =====
// Sequencer that walks the free list in header memory and updates it.
module sfa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_wdata,
	sfa_req_if.sink                req,
	sfa_rsp_if.source              rsp,
	output sfa_pkg::wr_t           wr,
	output logic [sfa_pkg::AW-1:0] raddr,
	input  sfa_pkg::hdr_t          rdata,
	output sfa_pkg::stat_t         stat
);
	localparam int AW = sfa_pkg::AW;
	localparam int SW = sfa_pkg::SW;
	localparam int EW = sfa_pkg::EW;
	localparam int PW = 2 * EW;

	sfa_pkg::state_t state_q, state_d;

	logic [1:0]    policy_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] head_q;
	logic          head_ok_q;

	logic          type_q;
	logic [PW-1:0] prod_q;
	logic [11:0]   off_q;

	logic [AW-1:0]    cur_q, prev_q, cand_q, cand_prev_q;
	logic             cur_ok_q, prev_ok_q, cand_prev_ok_q, found_q;
	sfa_pkg::hdr_t    prev_hdr_q, cand_hdr_q, cand_prev_hdr_q, cur_hdr_q, hd_hdr_q;

	logic [2:0]    res_st_q;
	logic [11:0]   res_off_q;
	logic          out_valid_q;
	logic [2:0]    out_st_q;
	logic [11:0]   out_off_q;

	// Derived request values.
	logic [EW-1:0]   cnt_eff;
	logic [SW-1:0]   size;
	logic [AW-1:0]   hd;
	logic            fits, take, first_kind, walk_stop;
	logic [AW+1:0]   split_sum;
	logic            split_ok;
	logic [AW-1:0]   split_addr;
	logic            nxt_ok;
	logic [AW-1:0]   nxt;
	logic            merge_cur, merge_prev;
	sfa_pkg::hdr_t   hd_new;
	logic            out_free;

	assign cnt_eff = (req.element_count == '0) ? EW'(1) : req.element_count;
	assign size    = prod_q[SW-1:0];
	assign hd      = AW'(off_q - 12'(sfa_pkg::HEADER_UNITS));

	// Fit decision for the node being read.
	assign fits       = rdata.size >= size;
	assign first_kind = (policy_q != sfa_pkg::FIT_BEST) && (policy_q != sfa_pkg::FIT_WORST);
	always_comb begin
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (policy_q == sfa_pkg::FIT_BEST) begin
				take = rdata.size < cand_hdr_q.size;
			end else if (policy_q == sfa_pkg::FIT_WORST) begin
				take = rdata.size > cand_hdr_q.size;
			end
		end
	end
	assign walk_stop = (fits && first_kind) || !rdata.has_next;

	// Split of the chosen block.
	assign split_sum  = (AW+2)'(cand_q) + (AW+2)'(sfa_pkg::HEADER_UNITS) + (AW+2)'(size);
	assign split_ok   = ((AW+2)'(cand_hdr_q.size) >= (AW+2)'(sfa_pkg::HEADER_UNITS) + (AW+2)'(size))
		&& (split_sum < (AW+2)'(sfa_pkg::ARENA_UNITS));
	assign split_addr = split_sum[AW-1:0];
	assign nxt_ok     = split_ok || cand_hdr_q.has_next;
	assign nxt        = split_ok ? split_addr : (cand_hdr_q.has_next ? cand_hdr_q.next : '0);

	// Merges on free.
	assign merge_cur = cur_ok_q && ((AW+2)'(hd) + (AW+2)'(sfa_pkg::HEADER_UNITS)
		+ (AW+2)'(hd_hdr_q.size) == (AW+2)'(cur_q));
	assign merge_prev = prev_ok_q && ((AW+2)'(prev_q) + (AW+2)'(sfa_pkg::HEADER_UNITS)
		+ (AW+2)'(prev_hdr_q.size) == (AW+2)'(hd));
	always_comb begin
		hd_new = hd_hdr_q;
		hd_new.occupied = 1'b0;
		hd_new.has_next = cur_ok_q;
		hd_new.next     = cur_ok_q ? cur_q : '0;
		if (merge_cur) begin
			hd_new.size     = SW'(hd_hdr_q.size + SW'(sfa_pkg::HEADER_UNITS) + cur_hdr_q.size);
			hd_new.has_next = cur_hdr_q.has_next;
			hd_new.next     = cur_hdr_q.next;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	// Next state, memory port and handshake.
	always_comb begin
		state_d   = state_q;
		wr        = '0;
		raddr     = cur_q;
		req.ready = 1'b0;
		unique case (state_q)
			sfa_pkg::S_CLEAR: begin
				wr.we   = 1'b1;
				wr.addr = clr_q;
				if (clr_q == '0) begin
					wr.data.size = SW'(sfa_pkg::ARENA_UNITS - sfa_pkg::HEADER_UNITS);
				end
				if (clr_q == '1) begin
					state_d = sfa_pkg::S_IDLE;
				end
			end
			sfa_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = sfa_pkg::S_START;
				end
			end
			sfa_pkg::S_START: begin
				if (type_q == sfa_pkg::REQ_ALLOC) begin
					raddr = head_q;
					if (prod_q > PW'(sfa_pkg::ARENA_UNITS) || !head_ok_q) begin
						state_d = sfa_pkg::S_DONE;
					end else begin
						state_d = sfa_pkg::S_WALK;
					end
				end else begin
					raddr = hd;
					if (off_q < 12'(sfa_pkg::HEADER_UNITS)) begin
						state_d = sfa_pkg::S_DONE;
					end else begin
						state_d = sfa_pkg::S_FCHK;
					end
				end
			end
			sfa_pkg::S_FCHK: begin
				raddr = head_q;
				if (!rdata.occupied) begin
					state_d = sfa_pkg::S_DONE;
				end else if (head_ok_q) begin
					state_d = sfa_pkg::S_WALK;
				end else begin
					state_d = sfa_pkg::S_F_WHD;
				end
			end
			sfa_pkg::S_WALK: begin
				raddr = rdata.next;
				if (type_q == sfa_pkg::REQ_ALLOC) begin
					if (walk_stop) begin
						state_d = (found_q || take) ? sfa_pkg::S_A_SPLIT : sfa_pkg::S_DONE;
					end
				end else if (!(cur_q < hd) || !rdata.has_next) begin
					state_d = sfa_pkg::S_F_WHD;
				end
			end
			sfa_pkg::S_A_SPLIT: begin
				wr.we             = split_ok;
				wr.addr           = split_addr;
				wr.data.occupied  = 1'b0;
				wr.data.size      = SW'(cand_hdr_q.size - SW'(sfa_pkg::HEADER_UNITS) - size);
				wr.data.has_next  = cand_hdr_q.has_next;
				wr.data.next      = cand_hdr_q.next;
				state_d           = sfa_pkg::S_A_CAND;
			end
			sfa_pkg::S_A_CAND: begin
				wr.we            = 1'b1;
				wr.addr          = cand_q;
				wr.data.occupied = 1'b1;
				wr.data.size     = split_ok ? size : cand_hdr_q.size;
				state_d          = sfa_pkg::S_A_PREV;
			end
			sfa_pkg::S_A_PREV: begin
				wr.we            = cand_prev_ok_q;
				wr.addr          = cand_prev_q;
				wr.data          = cand_prev_hdr_q;
				wr.data.has_next = nxt_ok;
				wr.data.next     = nxt;
				state_d          = sfa_pkg::S_DONE;
			end
			sfa_pkg::S_F_WHD: begin
				wr.we   = 1'b1;
				wr.addr = hd;
				wr.data = hd_new;
				state_d = sfa_pkg::S_F_WPREV;
			end
			sfa_pkg::S_F_WPREV: begin
				wr.we   = prev_ok_q;
				wr.addr = prev_q;
				wr.data = prev_hdr_q;
				if (merge_prev) begin
					wr.data.size     = SW'(prev_hdr_q.size + SW'(sfa_pkg::HEADER_UNITS)
						+ hd_hdr_q.size);
					wr.data.has_next = hd_hdr_q.has_next;
					wr.data.next     = hd_hdr_q.next;
				end else begin
					wr.data.has_next = 1'b1;
					wr.data.next     = hd;
				end
				state_d = sfa_pkg::S_DONE;
			end
			sfa_pkg::S_DONE: begin
				if (out_free) begin
					state_d = sfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sfa_pkg::S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: policy, clear sweep, list head, output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= sfa_pkg::FIT_FIRST;
			clr_q       <= '0;
			head_q      <= '0;
			head_ok_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			if (state_q == sfa_pkg::S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == sfa_pkg::S_A_PREV && !cand_prev_ok_q) begin
				head_ok_q <= nxt_ok;
				head_q    <= nxt;
			end
			if (state_q == sfa_pkg::S_F_WPREV && !prev_ok_q) begin
				head_ok_q <= 1'b1;
				head_q    <= hd;
			end
			if (state_q == sfa_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request datapath and list walk registers.
	always_ff @(posedge clk) begin
		if (state_q == sfa_pkg::S_IDLE && req.valid) begin
			type_q    <= req.req_type;
			prod_q    <= req.element_size * cnt_eff;
			off_q     <= req.release_offset;
			res_st_q  <= sfa_pkg::ST_OK;
			res_off_q <= '0;
		end
		case (state_q)
			sfa_pkg::S_START: begin
				cur_q     <= head_q;
				cur_ok_q  <= head_ok_q;
				prev_ok_q <= 1'b0;
				found_q   <= 1'b0;
				if (type_q == sfa_pkg::REQ_ALLOC) begin
					if (prod_q > PW'(sfa_pkg::ARENA_UNITS)) begin
						res_st_q <= sfa_pkg::ST_TOO_BIG;
					end else if (!head_ok_q) begin
						res_st_q <= sfa_pkg::ST_NO_FIT;
					end
				end else if (off_q == '0) begin
					res_st_q <= sfa_pkg::ST_NULL_FREE;
				end else if (off_q < 12'(sfa_pkg::HEADER_UNITS)) begin
					res_st_q <= sfa_pkg::ST_NOT_OCC;
				end
			end
			sfa_pkg::S_FCHK: begin
				hd_hdr_q <= rdata;
				if (!rdata.occupied) begin
					res_st_q <= sfa_pkg::ST_NOT_OCC;
				end
			end
			sfa_pkg::S_WALK: begin
				if (type_q == sfa_pkg::REQ_ALLOC) begin
					if (take) begin
						found_q         <= 1'b1;
						cand_q          <= cur_q;
						cand_hdr_q      <= rdata;
						cand_prev_q     <= prev_q;
						cand_prev_ok_q  <= prev_ok_q;
						cand_prev_hdr_q <= prev_hdr_q;
					end
					if (walk_stop && !found_q && !take) begin
						res_st_q <= sfa_pkg::ST_NO_FIT;
					end
					prev_q     <= cur_q;
					prev_hdr_q <= rdata;
					prev_ok_q  <= 1'b1;
					cur_q      <= rdata.next;
				end else if (cur_q < hd) begin
					prev_q     <= cur_q;
					prev_hdr_q <= rdata;
					prev_ok_q  <= 1'b1;
					cur_q      <= rdata.next;
					cur_ok_q   <= rdata.has_next;
				end else begin
					cur_hdr_q <= rdata;
					cur_ok_q  <= cur_q > hd;
				end
			end
			sfa_pkg::S_A_PREV: begin
				res_off_q <= 12'(cand_q + AW'(sfa_pkg::HEADER_UNITS));
			end
			sfa_pkg::S_F_WHD: begin
				hd_hdr_q <= hd_new;
			end
			sfa_pkg::S_DONE: begin
				if (out_free) begin
					out_st_q  <= res_st_q;
					out_off_q <= res_off_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_st_q;
	assign rsp.payload_offset = out_off_q;

	assign stat.clearing = (state_q == sfa_pkg::S_CLEAR);
	assign stat.idle     = (state_q == sfa_pkg::S_IDLE);
endmodule

// ===== bench/tb_sorted_free_list_allocator_top.sv =====
// Testbench of the free-list allocator: a header-level predictor checks every response beat.
module tb_sorted_free_list_allocator_top;
	localparam int unsigned ARENA = sfa_pkg::ARENA_UNITS;
	localparam int unsigned HDR   = sfa_pkg::HEADER_UNITS;
	localparam logic [1:0]  FIT_SPARE = 2'd3;

	typedef struct {
		bit          occ;
		bit          linked;
		int unsigned nxt;
		int unsigned sz;
	} blk_t;

	typedef struct {
		logic [2:0]  status;
		logic [11:0] offset;
	} rsp_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	sfa_req_if req ();
	sfa_rsp_if rsp ();

	sorted_free_list_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	// Predicted arena: one header record per unit offset.
	blk_t        arena [ARENA];
	bit          head_ok;
	int unsigned head_at;
	logic [1:0]  policy;

	rsp_t        pending_rsp [$];
	int unsigned live_offsets [$];
	int unsigned n_errors;
	int unsigned n_checked;
	int unsigned n_sent;
	int unsigned n_allocated;
	int unsigned n_released;
	bit          idle_on;
	int unsigned hold_left = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;

	// Clock with a period of 4.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Timeout guard.
	initial begin
		#4000000;
		$display("FAIL sorted_free_list_allocator_top");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("mismatch in %s: got %0d, expected %0d (beat %0d)", what, got, want, n_checked);
	endtask

	// Relinks the predecessor of a list position, or the head when there is none.
	function automatic void relink(bit has_prev, int unsigned prev, bit ok, int unsigned tgt);
		if (has_prev) begin
			arena[prev].linked = ok;
			arena[prev].nxt = ok ? tgt : 0;
		end else begin
			head_ok = ok;
			head_at = ok ? tgt : 0;
		end
	endfunction

	function automatic bit adjacent(int unsigned lo, int unsigned hi);
		return lo < ARENA && lo + HDR + arena[lo].sz == hi;
	endfunction

	// Places a request of need units by the current policy.
	function automatic void place_block(int unsigned need, output logic [2:0] st,
			output int unsigned pay);
		bit          found, walk, take, has_prev, cand_has_prev, succ_ok;
		int unsigned cur, prev, cand, cand_prev, steps, bs, succ, cut;
		found = 0; has_prev = 0; cand_has_prev = 0;
		prev = 0; cand = 0; cand_prev = 0; steps = 0;
		walk = head_ok; cur = head_at;
		pay = 0;
		while (walk && cur < ARENA && steps < ARENA) begin
			bs = arena[cur].sz;
			if (bs >= need) begin
				if (!found)
					take = 1;
				else if (policy == sfa_pkg::FIT_BEST)
					take = bs < arena[cand].sz;
				else if (policy == sfa_pkg::FIT_WORST)
					take = bs > arena[cand].sz;
				else
					take = 0;
				if (take) begin
					found = 1;
					cand = cur;
					cand_prev = prev;
					cand_has_prev = has_prev;
				end
			end
			// First fit (and the unused code) stops at the first candidate.
			if (found && policy != sfa_pkg::FIT_BEST && policy != sfa_pkg::FIT_WORST) begin
				walk = 0;
			end else begin
				prev = cur;
				has_prev = 1;
				walk = arena[cur].linked;
				cur = arena[cur].nxt;
				steps++;
			end
		end
		if (!found) begin
			st = sfa_pkg::ST_NO_FIT;
			return;
		end
		succ_ok = arena[cand].linked;
		succ = arena[cand].nxt;
		if (arena[cand].sz >= HDR + need) begin
			cut = cand + HDR + need;
			if (cut < ARENA) begin
				arena[cut].occ = 0;
				arena[cut].sz = arena[cand].sz - HDR - need;
				arena[cut].linked = arena[cand].linked;
				arena[cut].nxt = arena[cand].nxt;
				succ_ok = 1;
				succ = cut;
				arena[cand].sz = need;
			end
		end
		arena[cand].occ = 1;
		arena[cand].linked = 0;
		arena[cand].nxt = 0;
		relink(cand_has_prev, cand_prev, succ_ok, succ);
		st = sfa_pkg::ST_OK;
		pay = cand + HDR;
	endfunction

	// Returns a block to the address-ordered list and merges it with its neighbors.
	function automatic logic [2:0] return_block(int unsigned at);
		int unsigned hd, prev, cur, steps;
		bit          has_prev, cur_ok;
		if (at == 0)
			return sfa_pkg::ST_NULL_FREE;
		if (at < HDR)
			return sfa_pkg::ST_NOT_OCC;
		hd = at - HDR;
		if (hd >= ARENA || !arena[hd].occ)
			return sfa_pkg::ST_NOT_OCC;
		prev = 0; has_prev = 0; steps = 0;
		cur = head_at; cur_ok = head_ok;
		while (cur_ok && cur < ARENA && cur < hd && steps < ARENA) begin
			prev = cur;
			has_prev = 1;
			cur_ok = arena[cur].linked;
			cur = arena[cur].nxt;
			steps++;
		end
		cur_ok = cur_ok && cur < ARENA && cur > hd;
		arena[hd].occ = 0;
		arena[hd].linked = cur_ok;
		arena[hd].nxt = cur_ok ? cur : 0;
		if (cur_ok && adjacent(hd, cur)) begin
			arena[hd].sz += HDR + arena[cur].sz;
			arena[hd].linked = arena[cur].linked;
			arena[hd].nxt = arena[cur].nxt;
		end
		relink(has_prev, prev, 1, hd);
		if (has_prev && adjacent(prev, hd)) begin
			arena[prev].sz += HDR + arena[hd].sz;
			arena[prev].linked = arena[hd].linked;
			arena[prev].nxt = arena[hd].nxt;
		end
		return sfa_pkg::ST_OK;
	endfunction

	// Computes the expected beat of one accepted request and updates the arena.
	function automatic void predict_request(logic kind, logic [12:0] esz, logic [12:0] ecnt,
			logic [11:0] rel);
		rsp_t        r;
		int unsigned need, pay, i;
		pay = 0;
		if (kind == sfa_pkg::REQ_ALLOC) begin
			need = esz * ((ecnt == 0) ? 1 : ecnt);
			if (need > ARENA)
				r.status = sfa_pkg::ST_TOO_BIG;
			else
				place_block(need, r.status, pay);
			if (r.status == sfa_pkg::ST_OK) begin
				live_offsets.insert(live_offsets.size(), pay & 32'hFFF);
				n_allocated++;
			end
		end else begin
			r.status = return_block(rel);
			if (r.status == sfa_pkg::ST_OK)
				n_released++;
			for (i = 0; i < live_offsets.size(); i++)
				if (live_offsets[i] == rel && r.status == sfa_pkg::ST_OK) begin
					live_offsets.delete(i);
					break;
				end
		end
		r.offset = pay[11:0];
		pending_rsp.insert(pending_rsp.size(), r);
	endfunction

	// Sends one request beat; valid stays high after acceptance until a later gap or req_quiet.
	task automatic send_req(input logic kind, input logic [12:0] esz, input logic [12:0] ecnt,
			input logic [11:0] rel);
		int unsigned gap;
		gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.element_size <= esz;
		req.element_count <= ecnt;
		req.release_offset <= rel;
		do
			@(posedge clk);
		while (!req.ready);
		predict_request(kind, esz, ecnt, rel);
		n_sent++;
	endtask

	task automatic send_alloc(input logic [12:0] esz, input logic [12:0] ecnt);
		send_req(sfa_pkg::REQ_ALLOC, esz, ecnt, 12'($urandom));
	endtask

	task automatic send_release(input logic [11:0] rel);
		send_req(sfa_pkg::REQ_FREE, 13'($urandom), 13'($urandom), rel);
	endtask

	task automatic req_quiet();
		req.valid <= 1'b0;
	endtask

	// Waits until every expected beat has arrived, then a little longer.
	task automatic drain();
		int unsigned guard;
		req_quiet();
		guard = 0;
		while (pending_rsp.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (50) @(posedge clk);
	endtask

	task automatic write_policy(input logic [1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy = val;
	endtask

	// Receiver: random stall bursts, plus a long hold-off when asked.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_asks != hold_seen) begin
			rsp.ready <= 1'b0;
			hold_seen <= hold_asks;
			hold_left <= 299;
		end else if (hold_left != 0) begin
			rsp.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp.ready <= 1'b0;
			hold_left <= $urandom_range(0, 5);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Response checker: compares each beat with the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected beat, status", rsp.status, -1);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.payload_offset !== want.offset)
					report_mismatch("payload_offset", rsp.payload_offset, want.offset);
			end
			n_checked++;
		end
	end

	// Null, bad and unoccupied frees; oversize, zero-size and no-fit allocates.
	task automatic test_corner_cases();
		send_release(12'd0);
		send_release(12'd5);
		send_release(12'd15);
		send_release(12'd4095);
		send_alloc(13'd4097, 13'd0);
		send_alloc(13'd8191, 13'd8191);
		send_alloc(13'd1, 13'd4097);
		send_alloc(13'd4096, 13'd1);
		send_alloc(13'd0, 13'd0);
		send_release(12'd16);
		send_alloc(13'd1, 13'd4080);
		send_alloc(13'd1, 13'd1);
		send_release(12'd16);
	endtask

	// Free-list order: fill the arena, free the ends, then merge it whole again.
	task automatic test_list_order();
		send_alloc(13'd64, 13'd1);
		send_alloc(13'd32, 13'd2);
		send_alloc(13'd3920, 13'd1);
		send_alloc(13'd1, 13'd0);
		send_release(12'd16);
		send_release(12'd176);
		send_release(12'd96);
		send_release(12'd96);
		send_alloc(13'd4080, 13'd1);
		send_release(12'd16);
	endtask

	// Random traffic: mostly small allocations and frees of live blocks.
	task automatic test_random(input int unsigned count);
		int unsigned i, pick, sel;
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55 || (pick < 85 && live_offsets.size() == 0)) begin
				send_alloc(13'($urandom_range(0, 96)), 13'($urandom_range(0, 4)));
			end else if (pick < 62) begin
				send_alloc(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
			end else if (pick < 85) begin
				sel = $urandom_range(0, live_offsets.size() - 1);
				send_release(12'(live_offsets[sel]));
			end else begin
				send_release(12'($urandom_range(0, 4095)));
			end
		end
	endtask

	// The receiver holds off while requests keep coming, so the input stalls.
	task automatic test_backpressure();
		hold_asks++;
		test_random(12);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 2'd0;
		req.valid = 1'b0;
		req.req_type = sfa_pkg::REQ_ALLOC;
		req.element_size = '0;
		req.element_count = '0;
		req.release_offset = '0;
		n_errors = 0; n_checked = 0; n_sent = 0;
		n_allocated = 0; n_released = 0;
		idle_on = 1'b1;
		policy = sfa_pkg::FIT_FIRST;
		foreach (arena[i]) arena[i] = '{0, 0, 0, 0};
		arena[0].sz = ARENA - HDR;
		head_ok = 1;
		head_at = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_corner_cases();
		test_list_order();
		write_policy(sfa_pkg::FIT_BEST);
		test_random(110);
		write_policy(sfa_pkg::FIT_WORST);
		test_random(110);
		write_policy(FIT_SPARE);
		test_random(60);
		write_policy(sfa_pkg::FIT_FIRST);
		test_backpressure();
		test_random(60);
		idle_on = 1'b0;
		test_random(60);
		drain();

		$display("covered %0d requests under all fit policies: %0d allocations, %0d frees",
			n_sent, n_allocated, n_released);
		$display("checked %0d response beats, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0 && pending_rsp.size() == 0)
			$display("PASS sorted_free_list_allocator_top");
		else
			$display("FAIL sorted_free_list_allocator_top");
		$finish;
	end
endmodule
